// ===== sv/tstmse_pkg.sv =====
// Shared widths, codes, payload types and helpers of the time-sorted table.
`default_nettype none

package tstmse_pkg;

  localparam int SIZE_W = 40;
  localparam int TIME_W = 32;
  localparam int CAP_W  = 48;
  // Exact running sum: one bit above the reported width covers 512 max-size entries.
  localparam int TOT_W  = 49;

  localparam logic [CAP_W-1:0] CAP_RESET = 48'd34359738368;  // 32 GiB

  // Input kind codes
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TRIM = 1'b1;

  // Result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // One table slot as stored in memory
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // One input item
  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] entry_size;
    logic [TIME_W-1:0] entry_time;
  } item_t;

  // One result beat
  typedef struct packed {
    logic              evicted;
    logic [SIZE_W-1:0] evicted_size;
    logic [TIME_W-1:0] evicted_time;
    logic [CAP_W-1:0]  total_size;
    logic              status;
    logic              last;
  } res_t;

  // Clamp the exact total to the reported width
  function automatic logic [CAP_W-1:0] sat_total(input logic [TOT_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = (v > TOT_W'({CAP_W{1'b1}})) ? {CAP_W{1'b1}} : v[CAP_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tstmse_ifs.sv =====
// Channel interfaces: input items, results and the capacity write port.
`default_nettype none

interface tstmse_in_if import tstmse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] entry_size;
  logic [TIME_W-1:0] entry_time;

  modport source (output valid, kind, entry_size, entry_time, input ready);
  modport sink   (input valid, kind, entry_size, entry_time, output ready);
endinterface

interface tstmse_out_if import tstmse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              evicted;
  logic [SIZE_W-1:0] evicted_size;
  logic [TIME_W-1:0] evicted_time;
  logic [CAP_W-1:0]  total_size;
  logic              status;
  logic              last;

  modport source (output valid, evicted, evicted_size, evicted_time, total_size, status,
                  last, input ready);
  modport sink   (input valid, evicted, evicted_size, evicted_time, total_size, status,
                  last, output ready);
endinterface

interface tstmse_cfg_if import tstmse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

// ===== sv/tstmse_core.sv =====
// Table sequencer: slot memory plus sorted insert, min-size scan and compaction.
`default_nettype none

module tstmse_core import tstmse_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic [CAP_W-1:0] cap,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_SCAN, S_ADD_PUT, S_MIN_START, S_MIN_SCAN, S_SHIFT_DN, S_EVICT, S_EMIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TOT_W-1:0]  total_r;
  logic [CNT_W-1:0]  idx_r;
  logic [SIZE_W-1:0] add_size_r;
  logic [TIME_W-1:0] add_time_r;
  logic [SIZE_W-1:0] best_size_r;
  logic [TIME_W-1:0] best_time_r;
  logic [CNT_W-1:0]  best_idx_r;
  res_t              res_r;

  // Slot memory, one write and one registered read per cycle
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              in_acc;
  logic              tbl_full;
  logic              over_cap;
  logic [CNT_W-1:0]  idx_inc;
  logic              scan_more;
  logic              scan_take;
  logic [SIZE_W-1:0] best_size_upd;
  logic [TIME_W-1:0] best_time_upd;
  logic [CNT_W-1:0]  best_idx_upd;
  logic [CNT_W-1:0]  best_idx_inc;
  logic              shift_go;
  logic              add_shift;
  logic [TOT_W-1:0]  tot_add;
  logic [TOT_W-1:0]  tot_sub;
  logic              more_evict;
  entry_t            new_entry;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  assign tbl_full  = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign over_cap  = (total_r > TOT_W'(cap)) && (cnt_r != '0);
  assign idx_inc   = CNT_W'(idx_r + 1'b1);
  assign scan_more = (idx_inc < cnt_r);
  assign new_entry = '{size: add_size_r, stamp: add_time_r};
  assign add_shift = (rd_data_r.stamp > add_time_r);
  assign tot_add   = total_r + TOT_W'(add_size_r);
  assign tot_sub   = total_r - TOT_W'(best_size_r);
  assign more_evict = (tot_sub > TOT_W'(cap)) && (cnt_r != CNT_W'(1));

  // Running minimum: first slot seeds it, strict less keeps the earliest tie
  always_comb begin
    scan_take     = (idx_r == '0) || (rd_data_r.size < best_size_r);
    best_size_upd = scan_take ? rd_data_r.size  : best_size_r;
    best_time_upd = scan_take ? rd_data_r.stamp : best_time_r;
    best_idx_upd  = scan_take ? idx_r           : best_idx_r;
    best_idx_inc  = CNT_W'(best_idx_upd + 1'b1);
    shift_go      = (best_idx_inc < cnt_r);
  end

  // Memory port control per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = new_entry;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_item.kind == KIND_ADD && !tbl_full) begin
          if (cnt_r == '0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{size: in_item.entry_size, stamp: in_item.entry_time};
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(cnt_r - 1'b1);
          end
        end
      end
      S_ADD_SCAN: begin
        // walk down from the top, moving later slots up by one
        wr_en   = 1'b1;
        wr_addr = idx_inc[IDX_W-1:0];
        if (add_shift) begin
          wr_data = rd_data_r;
          if (idx_r != '0) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(idx_r - 1'b1);
          end
        end
      end
      S_ADD_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_MIN_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_MIN_SCAN: begin
        if (scan_more) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[IDX_W-1:0];
        end else if (shift_go) begin
          rd_en   = 1'b1;
          rd_addr = best_idx_inc[IDX_W-1:0];
        end
      end
      S_SHIFT_DN: begin
        // close the gap left by the evicted slot
        wr_en   = 1'b1;
        wr_addr = IDX_W'(idx_r - 1'b1);
        wr_data = rd_data_r;
        if (scan_more) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[IDX_W-1:0];
        end
      end
      S_EVICT, S_EMIT: begin
      end
    endcase
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            add_size_r <= in_item.entry_size;
            add_time_r <= in_item.entry_time;
            if (in_item.kind == KIND_ADD) begin
              if (tbl_full) begin
                res_r   <= '{evicted: 1'b0, evicted_size: '0, evicted_time: '0,
                             total_size: sat_total(total_r), status: ST_FULL, last: 1'b1};
                state_r <= S_EMIT;
              end else if (cnt_r == '0) begin
                cnt_r   <= CNT_W'(1);
                total_r <= TOT_W'(in_item.entry_size);
                res_r   <= '{evicted: 1'b0, evicted_size: '0, evicted_time: '0,
                             total_size: sat_total(TOT_W'(in_item.entry_size)),
                             status: ST_OK, last: 1'b1};
                state_r <= S_EMIT;
              end else begin
                idx_r   <= CNT_W'(cnt_r - 1'b1);
                state_r <= S_ADD_SCAN;
              end
            end else if (over_cap) begin
              state_r <= S_MIN_START;
            end else begin
              res_r   <= '{evicted: 1'b0, evicted_size: '0, evicted_time: '0,
                           total_size: sat_total(total_r), status: ST_OK, last: 1'b1};
              state_r <= S_EMIT;
            end
          end
        end
        S_ADD_SCAN: begin
          if (add_shift && idx_r != '0) begin
            idx_r <= CNT_W'(idx_r - 1'b1);
          end else if (add_shift) begin
            state_r <= S_ADD_PUT;
          end else begin
            cnt_r   <= CNT_W'(cnt_r + 1'b1);
            total_r <= tot_add;
            res_r   <= '{evicted: 1'b0, evicted_size: '0, evicted_time: '0,
                         total_size: sat_total(tot_add), status: ST_OK, last: 1'b1};
            state_r <= S_EMIT;
          end
        end
        S_ADD_PUT: begin
          cnt_r   <= CNT_W'(cnt_r + 1'b1);
          total_r <= tot_add;
          res_r   <= '{evicted: 1'b0, evicted_size: '0, evicted_time: '0,
                       total_size: sat_total(tot_add), status: ST_OK, last: 1'b1};
          state_r <= S_EMIT;
        end
        S_MIN_START: begin
          idx_r   <= '0;
          state_r <= S_MIN_SCAN;
        end
        S_MIN_SCAN: begin
          best_size_r <= best_size_upd;
          best_time_r <= best_time_upd;
          best_idx_r  <= best_idx_upd;
          if (scan_more) begin
            idx_r <= idx_inc;
          end else if (shift_go) begin
            idx_r   <= best_idx_inc;
            state_r <= S_SHIFT_DN;
          end else begin
            state_r <= S_EVICT;
          end
        end
        S_SHIFT_DN: begin
          if (scan_more) begin
            idx_r <= idx_inc;
          end else begin
            state_r <= S_EVICT;
          end
        end
        S_EVICT: begin
          cnt_r   <= CNT_W'(cnt_r - 1'b1);
          total_r <= tot_sub;
          res_r   <= '{evicted: 1'b1, evicted_size: best_size_r, evicted_time: best_time_r,
                       total_size: sat_total(tot_sub), status: ST_OK, last: !more_evict};
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state_r <= res_r.last ? S_IDLE : S_MIN_START;
          end
        end
      endcase
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same slot in one cycle");

  a_evict_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |-> (total_r >= TOT_W'(best_size_r)) && (cnt_r != '0))
    else $error("eviction from an empty table or below zero total");

  a_evict_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.evicted) |-> (res_r.status == ST_OK))
    else $error("eviction result flagged full");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_PUT) |=> (cnt_r == CNT_W'($past(cnt_r) + 1'b1)))
    else $error("insert at head did not grow the table");

endmodule

`default_nettype wire

// ===== sv/time_sorted_table_min_size_eviction.sv =====
// Top level: capacity register, table sequencer and the result output register.
//
// Holds up to TABLE_DEPTH (size, time) entries in a slot memory, sorted by time with
// equal times placed after earlier arrivals. An add takes one walk from the top of
// the table down to the insert point, one slot per cycle, and gives one result. A
// trim removes smallest-size entries (earliest in time order on a tie) until the
// total is at most capacity; each removal is a full scan of the held slots followed
// by a compaction of the slots above the removed one, one memory access a cycle, and
// gives one result, and a trim that removes nothing gives one result. The slot
// memory has a single read and a single write port. Items are taken one at a time;
// a finished result sits in the output register while the next item is accepted.
// Capacity resets to 32 GiB and may be written only while the block is idle.
`default_nettype none

module time_sorted_table_min_size_eviction import tstmse_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  tstmse_in_if.sink    in_bus,
  tstmse_out_if.source out_bus,
  tstmse_cfg_if.sink   cfg_bus
);

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  res_t             out_res_r;

  item_t            core_item;
  logic             core_res_valid;
  logic             core_res_ready;
  res_t             core_res;

  // Capacity register, always writable
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_bus.valid) begin
      cap_r <= cfg_bus.capacity;
    end
  end

  assign core_item = '{kind: in_bus.kind, entry_size: in_bus.entry_size,
                       entry_time: in_bus.entry_time};

  tstmse_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_item   (core_item),
    .cap       (cap_r),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // Output register: refills on the beat it drains
  assign core_res_ready = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_r <= core_res_valid;
      if (core_res_valid) begin
        out_res_r <= core_res;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.evicted      = out_res_r.evicted;
  assign out_bus.evicted_size = out_res_r.evicted_size;
  assign out_bus.evicted_time = out_res_r.evicted_time;
  assign out_bus.total_size   = out_res_r.total_size;
  assign out_bus.status       = out_res_r.status;
  assign out_bus.last         = out_res_r.last;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the time-sorted table with smallest-size eviction.
module tb;
  import tstmse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 16;
  localparam int SETTLE = 8;    // idle cycles before a capacity write
  localparam int DRAIN  = 40;   // cycles after the last expected beat
  localparam int RAND_ITEMS = 230;
  localparam logic [SIZE_W-1:0] MAX_SIZE = {SIZE_W{1'b1}};
  localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};
  localparam logic [CAP_W-1:0]  MAX_CAP  = {CAP_W{1'b1}};

  // One entry of the send queue: an item or a capacity write
  typedef struct {
    bit               is_cap;
    logic [CAP_W-1:0] cap;
    item_t            item;
  } table_op_t;

  logic clk = 1'b0;
  logic rst_n;

  tstmse_in_if  in_bus();
  tstmse_out_if out_bus();
  tstmse_cfg_if cfg_bus();

  time_sorted_table_min_size_eviction #(.TABLE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  table_op_t table_ops[$];
  res_t      expected_beats[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  // Table mirror
  logic [SIZE_W-1:0] held_size[DEPTH];
  logic [TIME_W-1:0] held_time[DEPTH];
  int                held_count = 0;
  logic [TOT_W-1:0]  held_total = '0;
  logic [CAP_W-1:0]  cap_model = CAP_RESET;

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    mismatches++;
    $display("%0t MISMATCH %s: got %0h expected %0h", $time, what, got_v, want_v);
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Build one expected beat from the current table total
  function automatic res_t table_beat(input logic ev, input logic [SIZE_W-1:0] sz,
                                      input logic [TIME_W-1:0] tm, input logic st,
                                      input logic lst);
    res_t r;
    r.evicted      = ev;
    r.evicted_size = sz;
    r.evicted_time = tm;
    r.total_size   = held_total[TOT_W-1] ? MAX_CAP : held_total[CAP_W-1:0];
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  // Apply one item to the mirror and queue the beats it causes
  task automatic predict_table_op(input item_t it);
    int                pos;
    int                best;
    int                removed;
    logic [SIZE_W-1:0] gone_size;
    logic [TIME_W-1:0] gone_time;
    bit                more;
    if (it.kind == KIND_ADD) begin
      if (held_count >= DEPTH) begin
        expected_beats.push_back(table_beat(1'b0, '0, '0, ST_FULL, 1'b1));
      end else begin
        // equal stamps go behind the ones already held
        pos = 0;
        while (pos < held_count && held_time[pos] <= it.entry_time) pos++;
        for (int k = held_count; k > pos; k--) begin
          held_size[k] = held_size[k-1];
          held_time[k] = held_time[k-1];
        end
        held_size[pos] = it.entry_size;
        held_time[pos] = it.entry_time;
        held_count++;
        held_total += it.entry_size;
        expected_beats.push_back(table_beat(1'b0, '0, '0, ST_OK, 1'b1));
      end
    end else begin
      removed = 0;
      while (held_total > cap_model && held_count > 0) begin
        // smallest size, earliest slot on a tie
        best = 0;
        for (int k = 1; k < held_count; k++)
          if (held_size[k] < held_size[best]) best = k;
        gone_size = held_size[best];
        gone_time = held_time[best];
        for (int k = best; k + 1 < held_count; k++) begin
          held_size[k] = held_size[k+1];
          held_time[k] = held_time[k+1];
        end
        held_count--;
        held_total -= gone_size;
        more = (held_total > cap_model) && (held_count > 0);
        expected_beats.push_back(table_beat(1'b1, gone_size, gone_time, ST_OK, !more));
        removed++;
      end
      if (removed == 0)
        expected_beats.push_back(table_beat(1'b0, '0, '0, ST_OK, 1'b1));
    end
  endtask

  // Stimulus helpers
  task automatic push_add(input logic [SIZE_W-1:0] sz, input logic [TIME_W-1:0] tm);
    table_op_t op;
    op.is_cap = 1'b0;
    op.cap = '0;
    op.item.kind = KIND_ADD;
    op.item.entry_size = sz;
    op.item.entry_time = tm;
    table_ops.push_back(op);
  endtask

  task automatic push_trim();
    table_op_t op;
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    op.is_cap = 1'b0;
    op.cap = '0;
    op.item.kind = KIND_TRIM;
    op.item.entry_size = junk[SIZE_W-1:0];
    op.item.entry_time = $urandom();
    table_ops.push_back(op);
  endtask

  task automatic push_cap(input logic [CAP_W-1:0] value);
    table_op_t op;
    op.is_cap = 1'b1;
    op.cap = value;
    op.item = '0;
    table_ops.push_back(op);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size(input int mode);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case (mode)
      0: return SIZE_W'($urandom_range(0, 1000));
      1: return r[SIZE_W-1:0];
      default: begin
        // a small pool so that equal sizes meet often
        case ($urandom_range(0, 3))
          0: return '0;
          1: return SIZE_W'(1);
          2: return SIZE_W'(2);
          default: return MAX_SIZE;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] rand_cap();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return MAX_CAP;
      2: return CAP_RESET;
      3: return r[CAP_W-1:0];
      4: return CAP_W'(r[42:0]);
      default: return CAP_W'($urandom_range(0, 8000));
    endcase
  endfunction

  task automatic build_directed();
    push_trim();                              // trim on an empty table
    push_add('0, '0);
    push_add(MAX_SIZE, MAX_TIME);
    push_add(40'd5, 32'd100);
    push_add(40'd5, 32'd100);                 // same stamp and size as held one
    push_add(40'd5, 32'd50);
    push_add('0, 32'd100);                    // zero size, trimmed right after the zero-size entry at time 0
    push_add(40'd7, 32'd100);
    push_add(40'd1, 32'h8000_0000);
    push_add(MAX_SIZE, '0);
    push_add(40'd3, 32'd100);
    push_add(40'h55_5555_5555, 32'hAAAA_AAAA);
    push_add(40'hAA_AAAA_AAAA, 32'h5555_5555);
    push_add(40'd5, 32'd100);
    push_add(40'd9, 32'd7);
    push_add(40'd2, 32'd100);
    push_add(40'd1, MAX_TIME);
    push_add(40'd123, 32'd5);                 // table full, dropped
    push_trim();                              // reset capacity: empties the table
    push_add(MAX_SIZE, 32'd5);
    push_add('0, 32'd5);
    push_cap(MAX_CAP);
    push_trim();                              // nothing to remove
    push_cap('0);
    push_trim();                              // removes everything
    push_trim();
  endtask

  // Phases of add bursts closed by a trim, with some stray trims
  task automatic build_random();
    int count;
    int size_mode;
    bit narrow_time;
    int burst;
    int rounds;
    count = 0;
    while (count < RAND_ITEMS) begin
      push_cap(rand_cap());
      size_mode = $urandom_range(0, 2);
      narrow_time = $urandom_range(0, 1);
      rounds = $urandom_range(15, 30);
      while (rounds > 0 && count < RAND_ITEMS) begin
        burst = $urandom_range(1, 10);
        while (burst > 0 && count < RAND_ITEMS) begin
          if ($urandom_range(0, 9) == 0) begin
            push_trim();
          end else begin
            push_add(($urandom_range(0, 5) == 0) ? rand_size(1) : rand_size(size_mode),
                     narrow_time ? TIME_W'($urandom_range(0, 15)) : TIME_W'($urandom()));
          end
          count++;
          burst--;
        end
        push_trim();
        count++;
        rounds--;
      end
    end
  endtask

  // Driver: items and capacity writes from the send queue
  int pending_items = 0;
  int quiet = 0;
  int hold = 0;
  always @(posedge clk) begin
    bit    in_done;
    logic  nxt_in_valid;
    logic  nxt_cfg_valid;
    in_done = in_bus.valid && in_bus.ready;
    nxt_in_valid = in_bus.valid && !in_bus.ready;
    nxt_cfg_valid = cfg_bus.valid && !cfg_bus.ready;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      if (in_done) pending_items++;
      if (out_bus.valid && out_bus.ready && out_bus.last) pending_items--;
      quiet = (pending_items == 0 && !in_done) ? quiet + 1 : 0;
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (hold > 0) begin
          hold--;
        end else if (table_ops.size() > 0) begin
          if (table_ops[0].is_cap) begin
            // capacity only changes with the block idle
            if (pending_items == 0 && quiet >= SETTLE) begin
              nxt_cfg_valid = 1'b1;
              cfg_bus.capacity <= table_ops[0].cap;
              void'(table_ops.pop_front());
            end
          end else begin
            nxt_in_valid = 1'b1;
            in_bus.kind <= table_ops[0].item.kind;
            in_bus.entry_size <= table_ops[0].item.entry_size;
            in_bus.entry_time <= table_ops[0].item.entry_time;
            void'(table_ops.pop_front());
            hold = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
          end
        end
      end
      in_bus.valid <= nxt_in_valid;
      cfg_bus.valid <= nxt_cfg_valid;
    end
  end

  // Result backpressure, with calm stretches of no stall
  int stall = 0;
  int calm_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(100, 300);
      calm = (calm_left > 0);
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall = gap_len() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: check result beats, then predict from accepted items and writes
  always @(posedge clk) begin
    res_t  got;
    res_t  want;
    item_t it;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.evicted      = out_bus.evicted;
        got.evicted_size = out_bus.evicted_size;
        got.evicted_time = out_bus.evicted_time;
        got.total_size   = out_bus.total_size;
        got.status       = out_bus.status;
        got.last         = out_bus.last;
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with none expected", 64'(got.total_size), 64'd0);
        end else begin
          want = expected_beats.pop_front();
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
          if (got.evicted_size !== want.evicted_size)
            report_mismatch("evicted_size", 64'(got.evicted_size), 64'(want.evicted_size));
          if (got.evicted_time !== want.evicted_time)
            report_mismatch("evicted_time", 64'(got.evicted_time), 64'(want.evicted_time));
          if (got.total_size !== want.total_size)
            report_mismatch("total_size", 64'(got.total_size), 64'(want.total_size));
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        it.kind = in_bus.kind;
        it.entry_size = in_bus.entry_size;
        it.entry_time = in_bus.entry_time;
        predict_table_op(it);
      end
      if (cfg_bus.valid && cfg_bus.ready) cap_model = cfg_bus.capacity;
    end
  end

  // Reset, stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_ADD;
    in_bus.entry_size = '0;
    in_bus.entry_time = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.capacity = CAP_RESET;
    out_bus.ready = 1'b0;
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (table_ops.size() != 0 || in_bus.valid || cfg_bus.valid ||
           expected_beats.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch("beats never seen", 64'(expected_beats.size()), 64'd0);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung block
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
